// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/mexp_pkg.sv =====
// Shared constants and types of the modular exponentiation core.
package mexp_pkg;

	// Datapath width in bits for base, exponent and modulus
	localparam int WIDTH = 32;
	// Width of a counter that indexes one bit of the datapath
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	// Sequencer states of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: sequencer, operand registers and stream ports.
// Computes base^exponent mod modulus by right-to-left square-and-multiply. The base is first
// reduced modulo the modulus, then each of the 32 exponent bits costs a squaring and, when the
// bit is set, one extra multiplication. All of these run on a single bit-serial modular
// multiplier. The reduction, each exponent bit and the load of the result into the output
// register keep the input side busy, as does any wait of the finished result for the previous
// one to leave; a modulus of 0 skips the multiplier and returns 0. The input side is not ready
// while a word is in work; the result sits in an output register, so a new word is taken while
// the previous result still waits. Write the modulus only while the core is idle; its reset
// value is 1.
module modular_exponentiation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,     // modulus
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // [31:0] base, [63:32] exponent
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [31:0] power_mod
);

	localparam logic [mexp_pkg::CNT_W-1:0] LAST = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
	localparam logic [mexp_pkg::WIDTH-1:0] ONE  = mexp_pkg::WIDTH'(1);

	mexp_pkg::state_t             state_q;
	mexp_pkg::state_t             state_d;
	logic [mexp_pkg::WIDTH-1:0]   modulus_q;
	logic [mexp_pkg::WIDTH-1:0]   exp_q;
	logic [mexp_pkg::WIDTH-1:0]   power_q;
	logic [mexp_pkg::WIDTH-1:0]   acc_q;
	logic [mexp_pkg::CNT_W-1:0]   bit_cnt_q;
	logic                         out_valid_q;
	logic [mexp_pkg::WIDTH-1:0]   power_mod_q;
	logic                         accept;
	logic                         out_load;
	logic                         mm_start;
	logic [mexp_pkg::WIDTH-1:0]   mm_a;
	logic [mexp_pkg::WIDTH-1:0]   mm_b;
	logic                         mm_done;
	logic [mexp_pkg::WIDTH-1:0]   mm_result;
	logic [mexp_pkg::WIDTH-1:0]   in_base;
	logic [mexp_pkg::WIDTH-1:0]   in_exp;

	assign in_base  = s_tdata[mexp_pkg::WIDTH-1:0];
	assign in_exp   = s_tdata[32 +: mexp_pkg::WIDTH];
	assign s_tready = (state_q == mexp_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == mexp_pkg::ST_FINISH) && (!out_valid_q || m_tready);

	// Shared modular multiplier
	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (modulus_q),
		.done   (mm_done),
		.result (mm_result)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (modulus_q == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (mm_done) state_d = mexp_pkg::ST_STEP;
			end
			mexp_pkg::ST_STEP: begin
				state_d = exp_q[0] ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
			end
			mexp_pkg::ST_MUL: begin
				if (mm_done) state_d = mexp_pkg::ST_SQR;
			end
			mexp_pkg::ST_SQR: begin
				if (mm_done) begin
					state_d = (bit_cnt_q == LAST) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_STEP;
				end
			end
			mexp_pkg::ST_FINISH: begin
				if (out_load) state_d = mexp_pkg::ST_IDLE;
			end
			default: state_d = mexp_pkg::ST_IDLE;
		endcase
	end

	// Multiplier commands and operands
	always_comb begin
		mm_start = 1'b0;
		mm_a     = power_q;
		mm_b     = power_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				mm_start = accept && (modulus_q != '0);
				mm_a     = ONE;
				mm_b     = in_base;
			end
			mexp_pkg::ST_STEP: begin
				mm_start = 1'b1;
				mm_a     = exp_q[0] ? acc_q : power_q;
			end
			mexp_pkg::ST_MUL: begin
				mm_start = mm_done;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			modulus_q   <= ONE;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) modulus_q <= cfg_wdata[mexp_pkg::WIDTH-1:0];
			if (accept) begin
				bit_cnt_q <= '0;
			end else if ((state_q == mexp_pkg::ST_SQR) && mm_done) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= in_exp;
			acc_q <= (modulus_q == ONE || modulus_q == '0) ? '0 : ONE;
		end
		if ((state_q == mexp_pkg::ST_REDUCE) && mm_done) begin
			power_q <= mm_result;
		end
		if ((state_q == mexp_pkg::ST_MUL) && mm_done) begin
			acc_q <= mm_result;
		end
		if ((state_q == mexp_pkg::ST_SQR) && mm_done) begin
			power_q <= mm_result;
			exp_q   <= exp_q >> 1;
		end
		if (out_load) begin
			power_mod_q <= acc_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 32'(power_mod_q);

endmodule

// ===== hdl/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: result = a * b mod m, one bit of b per cycle.
module mexp_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mexp_pkg::WIDTH-1:0]  a,
	input  logic [mexp_pkg::WIDTH-1:0]  b,
	input  logic [mexp_pkg::WIDTH-1:0]  m,
	output logic                        done,
	output logic [mexp_pkg::WIDTH-1:0]  result
);

	localparam int XW = mexp_pkg::WIDTH + 2;
	localparam logic [mexp_pkg::CNT_W-1:0] LAST = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);

	logic                         busy_q;
	logic                         done_q;
	logic [mexp_pkg::CNT_W-1:0]   cnt_q;
	logic [mexp_pkg::WIDTH-1:0]   a_q;
	logic [mexp_pkg::WIDTH-1:0]   b_q;
	logic [mexp_pkg::WIDTH-1:0]   r_q;
	logic [XW-1:0]                x;
	logic [XW-1:0]                m1_ext;
	logic [XW-1:0]                m2_ext;
	logic [XW-1:0]                x_red;

	// Double the remainder, add a when the next bit of b is set, fold back below m
	always_comb begin
		m1_ext = {2'b00, m};
		m2_ext = {1'b0, m, 1'b0};
		x      = {1'b0, r_q, 1'b0} + (b_q[mexp_pkg::WIDTH-1] ? {2'b00, a_q} : '0);
		if (x >= m2_ext) begin
			x_red = x - m2_ext;
		end else if (x >= m1_ext) begin
			x_red = x - m1_ext;
		end else begin
			x_red = x;
		end
	end

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Hold operands and advance the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[mexp_pkg::WIDTH-2:0], 1'b0};
			r_q <= x_red[mexp_pkg::WIDTH-1:0];
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// ===== hdl/mexp_checker.sv =====
// Port-level checker for the modular exponentiation core and its bind.
`include "assert_macros.svh"

module mexp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic [31:0] cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result word holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// The core is busy right after it takes a word
	`ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Ready only drops because a word was taken
	`ASSERT_IMP(a_ready_drop, clk, arst_n, $fell(s_tready), $past(s_tvalid))
	// A result appears exactly as the core goes idle again
	`ASSERT_IMP(a_result_with_idle, clk, arst_n, $rose(m_tvalid), $rose(s_tready))

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);
